### src/mac_pkg.sv
// ----------------------------------------------------------------------------
// mac_pkg
// Shared types, codes and helpers of the motion alarm controller.
// ----------------------------------------------------------------------------
package mac_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [1:0] {
    MODE_DISARMED = 2'd0,
    MODE_ARMED    = 2'd1,
    MODE_ALARM    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    SND_NONE    = 3'd0,
    SND_WARNING = 3'd1,
    SND_ARM     = 3'd2,
    SND_DISARM  = 3'd3,
    SND_ALARM   = 3'd4
  } snd_t;

  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_MOTION = 3'd1;
  localparam logic [2:0] REQ_TOUCH  = 3'd2;
  localparam logic [2:0] REQ_LOCAL  = 3'd3;
  localparam logic [2:0] REQ_REMOTE = 3'd4;

  localparam logic [2:0] CMD_ARM    = 3'd0;
  localparam logic [2:0] CMD_DISARM = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_STATUS = 3'd3;
  localparam logic [2:0] CMD_RAISE  = 3'd4;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WINDOW    = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE  = 2'd2;
  localparam logic [1:0] REG_DURATION  = 2'd3;

  typedef struct packed {
    logic [15:0] motion_threshold;
    logic [31:0] warning_window_ms;
    logic [31:0] debounce_ms;
    logic [31:0] alarm_duration_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] motion_value;
    logic [2:0]  command;
  } item_t;

  typedef struct packed {
    mode_t       mode_now;
    logic        relay_on;
    logic        alarm_sounding;
    logic        detection_on;
    logic        sound_stop;
    snd_t        sound_start;
    logic        status_report;
    logic [15:0] alarm_total;
  } res_t;

  // Clamp the alarm counter to the 16-bit result field.
  function automatic logic [15:0] clamp_total(count_t c);
    logic [31:0] c32;
    c32 = 32'(c);
    if (c32 > 32'h0000_FFFF) begin
      return 16'hFFFF;
    end
    return c32[15:0];
  endfunction

endpackage

### src/mac_regs.sv
// ----------------------------------------------------------------------------
// mac_regs
// APB configuration registers: threshold, warning window, debounce, duration.
// ----------------------------------------------------------------------------
module mac_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mac_pkg::ADDR_W-1:0]  paddr,
  input  logic [mac_pkg::DATA_W-1:0]  pwdata,
  output logic [mac_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output mac_pkg::cfg_t               cfg
);
  import mac_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.motion_threshold  <= 16'd512;
      cfg.warning_window_ms <= 32'd10000;
      cfg.debounce_ms       <= 32'd500;
      cfg.alarm_duration_ms <= 32'd30000;
    end else if (wr_en) begin
      case (reg_sel)
        REG_THRESHOLD: cfg.motion_threshold  <= pwdata[15:0];
        REG_WINDOW:    cfg.warning_window_ms <= pwdata;
        REG_DEBOUNCE:  cfg.debounce_ms       <= pwdata;
        REG_DURATION:  cfg.alarm_duration_ms <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_THRESHOLD: prdata = {16'd0, cfg.motion_threshold};
      REG_WINDOW:    prdata = cfg.warning_window_ms;
      REG_DEBOUNCE:  prdata = cfg.debounce_ms;
      REG_DURATION:  prdata = cfg.alarm_duration_ms;
      default:       prdata = '0;
    endcase
  end

endmodule

### src/mac_fsm.sv
// ----------------------------------------------------------------------------
// mac_fsm
// Mode state, timers and alarm counter; computes one result per item.
// ----------------------------------------------------------------------------
module mac_fsm (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  mac_pkg::item_t item,
  input  mac_pkg::cfg_t  cfg,
  output mac_pkg::res_t  res
);
  import mac_pkg::*;

  typedef struct packed {
    logic [31:0] time_ms;
    mode_t       mode;
    logic [31:0] last_warning_ms;
    logic [31:0] mode_entry_ms;
    logic        sounding;
    logic        relay;
    logic        detect;
    count_t      alarm_count;
    logic        snd_stop;
    snd_t        snd_start;
    logic        report;
  } work_t;

  logic [31:0] time_ms;
  mode_t       mode;
  logic [31:0] last_warning_ms;
  logic [31:0] mode_entry_ms;
  logic        sounding;
  logic        relay;
  logic        detect;
  count_t      alarm_count;

  work_t       w;
  logic [31:0] since;
  logic [31:0] time_inc;

  function automatic work_t f_set_mode(work_t s, mode_t m);
    if (s.mode != m) begin
      s.mode          = m;
      s.mode_entry_ms = s.time_ms;
    end
    return s;
  endfunction

  function automatic work_t f_raise(work_t s);
    s.snd_start = SND_ALARM;
    s.sounding  = 1'b1;
    if (s.alarm_count != '1) begin
      s.alarm_count = s.alarm_count + count_t'(1);
    end
    return s;
  endfunction

  function automatic work_t f_stop(work_t s);
    s.snd_stop = 1'b1;
    s.sounding = 1'b0;
    if (s.mode == MODE_ALARM) begin
      s = f_set_mode(s, MODE_ARMED);
    end
    return s;
  endfunction

  function automatic work_t f_trigger(work_t s);
    if (s.mode == MODE_ARMED) begin
      s = f_set_mode(s, MODE_ALARM);
      s = f_raise(s);
    end
    return s;
  endfunction

  function automatic work_t f_arm(work_t s);
    s.relay     = 1'b0;
    s.snd_start = SND_ARM;
    if (s.mode == MODE_DISARMED) begin
      s.detect = 1'b1;
      s        = f_set_mode(s, MODE_ARMED);
    end
    return s;
  endfunction

  function automatic work_t f_disarm(work_t s);
    if (s.mode != MODE_DISARMED) begin
      s        = f_stop(s);
      s.relay  = 1'b1;
      s.detect = 1'b0;
      s        = f_set_mode(s, MODE_DISARMED);
    end
    s.snd_start = SND_DISARM;
    return s;
  endfunction

  assign since    = time_ms - last_warning_ms;
  assign time_inc = time_ms + 32'd1;

  always_comb begin
    w.time_ms         = time_ms;
    w.mode            = mode;
    w.last_warning_ms = last_warning_ms;
    w.mode_entry_ms   = mode_entry_ms;
    w.sounding        = sounding;
    w.relay           = relay;
    w.detect          = detect;
    w.alarm_count     = alarm_count;
    w.snd_stop        = 1'b0;
    w.snd_start       = SND_NONE;
    w.report          = 1'b0;
    case (item.req_type)
      REQ_TICK: begin
        w.time_ms = time_inc;
        if (mode == MODE_ALARM &&
            (time_inc - mode_entry_ms) >= cfg.alarm_duration_ms) begin
          w       = f_stop(w);
          w.relay = 1'b0;
        end
      end
      REQ_MOTION: begin
        if (mode == MODE_ARMED) begin
          if (item.motion_value > cfg.motion_threshold) begin
            w = f_trigger(w);
          end else if (since > cfg.warning_window_ms) begin
            w.snd_start       = SND_WARNING;
            w.last_warning_ms = time_ms;
          end else if (since > cfg.debounce_ms) begin
            w = f_trigger(w);
          end
        end
      end
      REQ_TOUCH: begin
        if (mode != MODE_DISARMED) begin
          w = f_disarm(w);
        end
      end
      REQ_LOCAL: begin
        case (item.command)
          CMD_ARM:    w = f_arm(w);
          CMD_DISARM: w = f_disarm(w);
          CMD_STOP:   w = f_stop(w);
          CMD_STATUS: w.report = 1'b1;
          default: ;
        endcase
      end
      REQ_REMOTE: begin
        // any remote beat silences a sounding alarm
        if (sounding) begin
          w = f_stop(w);
        end else begin
          case (item.command)
            CMD_ARM:    w = f_arm(w);
            CMD_DISARM: w = f_disarm(w);
            CMD_RAISE:  w = f_raise(w);
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.mode_now       = w.mode;
    res.relay_on       = w.relay;
    res.alarm_sounding = w.sounding;
    res.detection_on   = w.detect;
    res.sound_stop     = w.snd_stop;
    res.sound_start    = w.snd_start;
    res.status_report  = w.report;
    res.alarm_total    = clamp_total(w.alarm_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_ms         <= '0;
      mode            <= MODE_DISARMED;
      last_warning_ms <= '0;
      mode_entry_ms   <= '0;
      sounding        <= 1'b0;
      relay           <= 1'b1;
      detect          <= 1'b0;
      alarm_count     <= '0;
    end else if (advance) begin
      time_ms         <= w.time_ms;
      mode            <= w.mode;
      last_warning_ms <= w.last_warning_ms;
      mode_entry_ms   <= w.mode_entry_ms;
      sounding        <= w.sounding;
      relay           <= w.relay;
      detect          <= w.detect;
      alarm_count     <= w.alarm_count;
    end
  end

endmodule

### src/motion_alarm_controller_top.sv
// ----------------------------------------------------------------------------
// motion_alarm_controller_top
// Theft-alarm mode controller: ticks, motion, touch and commands in, one
// mode/relay/sound result out per input beat.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | in_valid/in_ready  | req_type, motion_value, command
//  output   | out_valid/out_ready| mode_now .. alarm_total
//  config   | APB psel/penable   | paddr, pwdata, prdata
//
//  One beat per cycle sustained while out_ready holds; each beat passes the
//  input register, then the mode logic once, then the result register.
//  Synchronous active-high reset restores the register defaults and the
//  disarmed mode with the relay on.
//  A stalled result holds in the output register; the input register keeps
//  taking beats until both stages are full.
// ----------------------------------------------------------------------------
module motion_alarm_controller_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  req_type,
  input  logic [15:0]                 motion_value,
  input  logic [2:0]                  command,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  mode_now,
  output logic                        relay_on,
  output logic                        alarm_sounding,
  output logic                        detection_on,
  output logic                        sound_stop,
  output logic [2:0]                  sound_start,
  output logic                        status_report,
  output logic [15:0]                 alarm_total,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mac_pkg::ADDR_W-1:0]  paddr,
  input  logic [mac_pkg::DATA_W-1:0]  pwdata,
  output logic [mac_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import mac_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  logic  in_full;
  res_t  res;
  res_t  out_res;
  logic  advance;

  mac_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mac_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .res     (res)
  );

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item.req_type     <= req_type;
      in_item.motion_value <= motion_value;
      in_item.command      <= command;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign mode_now       = out_res.mode_now;
  assign relay_on       = out_res.relay_on;
  assign alarm_sounding = out_res.alarm_sounding;
  assign detection_on   = out_res.detection_on;
  assign sound_stop     = out_res.sound_stop;
  assign sound_start    = out_res.sound_start;
  assign status_report  = out_res.status_report;
  assign alarm_total    = out_res.alarm_total;

`ifndef SYNTHESIS
  a_armed_relay_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode_now != MODE_DISARMED |-> !relay_on)
    else $error("relay on outside disarmed mode");

  a_detect_follows_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> detection_on == (mode_now != MODE_DISARMED))
    else $error("detection does not follow mode");

  a_alarm_start_sounds: assert property (@(posedge clk) disable iff (rst)
    out_valid && sound_start == SND_ALARM |-> alarm_sounding)
    else $error("alarm sound started but not sounding");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    in_full && (!out_valid || out_ready) |=> out_valid)
    else $error("held beat did not reach the result register");
`endif

endmodule
